// File: hdl/atr_pkg.sv
package atr_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int PRICE_BITS   = 32;
   localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS   = 7;
   localparam int TOTAL_BITS   = PRICE_BITS + SLOT_BITS;
   localparam int FRAC_BITS    = 8;
   localparam int SCALE_BITS   = TOTAL_BITS + FRAC_BITS;
   localparam int MEAN_BITS    = 40;
   localparam int DIV_CNT_BITS = $clog2(SCALE_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(14);
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   typedef struct packed {
      logic load;
      logic calc_range;
      logic sub_old;
      logic add_new;
      logic check;
      logic div_run;
   } atr_cmd_type;

   typedef struct packed {
      logic have_last;
      logic full;
      logic div_last;
   } atr_status_type;

endpackage

// File: hdl/atr_dp.sv
module atr_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic [atr_pkg::COUNT_BITS-1:0]     window_length,
   input  logic [atr_pkg::PRICE_BITS-1:0]     high_price,
   input  logic [atr_pkg::PRICE_BITS-1:0]     low_price,
   input  logic [atr_pkg::PRICE_BITS-1:0]     close_price,
   input  atr_pkg::atr_cmd_type               cmd,
   output atr_pkg::atr_status_type            status,
   output logic [atr_pkg::MEAN_BITS-1:0]      range_mean,
   output logic                               mean_valid
);
   import atr_pkg::*;

   logic [PRICE_BITS-1:0] high_ff, low_ff, close_ff;
   logic [PRICE_BITS-1:0] tr_ff, old_ff;
   logic [PRICE_BITS-1:0] last_close_ff, last_close_in;
   logic                  have_last_ff, have_last_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] held_ff, held_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SCALE_BITS-1:0] div_ff, div_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  mean_ok_ff, mean_ok_in;

   logic [PRICE_BITS-1:0] ring_mem [0:MAX_WINDOW-1];

   logic [COUNT_BITS-1:0] w_eff;
   logic                  full;
   logic [COUNT_BITS-1:0] slot_inc;
   logic [PRICE_BITS-1:0] d_hl, d_hc, d_lc, tr_max;
   logic [COUNT_BITS:0]   trial;
   logic                  trial_ge;

   function automatic logic [PRICE_BITS-1:0] abs_diff(input logic [PRICE_BITS-1:0] a,
                                                     input logic [PRICE_BITS-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      if (window_length == '0) begin
         w_eff = COUNT_BITS'(1);
      end else if (window_length > COUNT_BITS'(MAX_WINDOW)) begin
         w_eff = COUNT_BITS'(MAX_WINDOW);
      end else begin
         w_eff = window_length;
      end
   end

   assign full     = (held_ff >= w_eff);
   assign slot_inc = {1'b0, slot_ff} + COUNT_BITS'(1);

   assign d_hl = abs_diff(high_ff, low_ff);
   assign d_hc = abs_diff(high_ff, last_close_ff);
   assign d_lc = abs_diff(low_ff, last_close_ff);

   always_comb begin
      tr_max = d_hl;
      if (d_hc > tr_max) begin
         tr_max = d_hc;
      end
      if (d_lc > tr_max) begin
         tr_max = d_lc;
      end
   end

   // one quotient bit per cycle, restoring
   assign trial    = {rem_ff, div_ff[SCALE_BITS-1]};
   assign trial_ge = (trial >= {1'b0, w_eff});

   always_comb begin
      last_close_in = last_close_ff;
      have_last_in  = have_last_ff;
      total_in      = total_ff;
      held_in       = held_ff;
      slot_in       = slot_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      mean_ok_in    = mean_ok_ff;

      if (restart) begin
         total_in = '0;
         held_in  = '0;
         slot_in  = '0;
      end
      if (cmd.sub_old && full) begin
         total_in = total_ff - {{(TOTAL_BITS-PRICE_BITS){1'b0}}, old_ff};
      end
      if (cmd.add_new) begin
         total_in = total_ff + {{(TOTAL_BITS-PRICE_BITS){1'b0}}, tr_ff};
         if (!full) begin
            held_in = held_ff + COUNT_BITS'(1);
         end
         slot_in = (slot_inc >= w_eff) ? '0 : slot_inc[SLOT_BITS-1:0];
      end
      if (cmd.check) begin
         last_close_in = close_ff;
         have_last_in  = 1'b1;
         mean_ok_in    = full;
         rem_in        = '0;
         cnt_in        = DIV_CNT_BITS'(SCALE_BITS - 1);
         div_in        = full ? {total_ff, {FRAC_BITS{1'b0}}} : '0;
      end
      if (cmd.div_run) begin
         rem_in = trial_ge ? COUNT_BITS'(trial - {1'b0, w_eff}) : trial[COUNT_BITS-1:0];
         div_in = {div_ff[SCALE_BITS-2:0], trial_ge};
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_close_ff <= '0;
         have_last_ff  <= 1'b0;
         total_ff      <= '0;
         held_ff       <= '0;
         slot_ff       <= '0;
         cnt_ff        <= '0;
         mean_ok_ff    <= 1'b0;
         div_ff        <= '0;
         rem_ff        <= '0;
      end else begin
         last_close_ff <= last_close_in;
         have_last_ff  <= have_last_in;
         total_ff      <= total_in;
         held_ff       <= held_in;
         slot_ff       <= slot_in;
         cnt_ff        <= cnt_in;
         mean_ok_ff    <= mean_ok_in;
         div_ff        <= div_in;
         rem_ff        <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         high_ff  <= high_price;
         low_ff   <= low_price;
         close_ff <= close_price;
      end
      if (cmd.calc_range) begin
         tr_ff  <= tr_max;
         old_ff <= ring_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_new) begin
         ring_mem[slot_ff] <= tr_ff;
      end
   end

   assign status.have_last = have_last_ff;
   assign status.full      = full;
   assign status.div_last  = (cnt_ff == '0);

   assign range_mean = div_ff[MEAN_BITS-1:0];
   assign mean_valid = mean_ok_ff;

`ifndef NO_ASSERTIONS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= w_eff)
      else $error("true range count exceeds window");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} < w_eff)
      else $error("ring slot outside window");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= {held_ff[SLOT_BITS:0], {PRICE_BITS{1'b0}}})
      else $error("window total larger than held ranges allow");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_run) |-> rem_ff < w_eff)
      else $error("divider remainder not below divisor");
`endif

endmodule

// File: hdl/atr_ctrl.sv
module atr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  atr_pkg::atr_status_type  status,
   input  logic                     out_free,
   output logic                     emit,
   output atr_pkg::atr_cmd_type     cmd
);
   import atr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RANGE = 3'd1;
   localparam logic [2:0] S_SUB   = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.have_last ? S_RANGE : S_CHECK;
            end
         end
         S_RANGE: begin
            cmd.calc_range = 1'b1;
            state_in       = S_SUB;
         end
         S_SUB: begin
            cmd.sub_old = 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.add_new = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.full ? S_DIV : S_DONE;
         end
         S_DIV: begin
            cmd.div_run = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register can take the word
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && status.full) |=> ##45 (state_ff == S_DIV && status.div_last))
      else $error("divide did not run its full length");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free && state_ff == S_DONE)
      else $error("result emitted while output busy");
`endif

endmodule

// File: hdl/average_true_range_top.sv
// Average true range over a sliding window of price bars. Each accepted bar
// (high, low, close) yields one result word: the mean of the last
// window_length true ranges in ticks with 8 fractional bits, truncated, and
// a valid flag that stays clear (mean 0) until that many true ranges exist.
// The first bar after reset only stores its close. Every later bar passes
// through the update steps range, subtract oldest, add newest and check;
// once the window is full these are followed by the bit-serial restoring
// divide of the 46-bit scaled sum by the window length, and then the word
// is handed to the output register. The controller then returns to idle to
// accept the next bar, so a bar is not taken before the controller is done
// with the previous one; a word still held in the output register by
// rsp_tready low stalls the hand-off. One bar is in flight at a time; the
// next bar is accepted while the previous result still waits in the output
// register. Writing window_length (byte address 0, only bits [6:0] kept,
// values 0 act as 1, above 64 act as 64) empties the window but keeps the
// last close; write it only while idle.
module average_true_range_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // high_price [31:0], low_price [63:32], close_price [95:64]
   input  logic [95:0]                       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // range_mean [39:0]
   output logic [39:0]                       rsp_tdata,
   // mean_valid [0]
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [atr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [atr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [atr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import atr_pkg::*;

   logic [COUNT_BITS-1:0] window_length_ff, window_length_in;
   logic                  csr_write;
   logic                  restart;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MEAN_BITS-1:0]  rsp_mean_ff;
   logic                  rsp_flag_ff;
   logic                  out_free;
   logic                  emit;
   logic [MEAN_BITS-1:0]  range_mean;
   logic                  mean_valid;
   atr_cmd_type           cmd;
   atr_status_type        status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign restart    = csr_write && (csr_paddr[2] == REG_WINDOW_LENGTH);
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_LENGTH)
                       ? {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, window_length_ff} : '0;

   assign window_length_in = restart ? csr_pwdata[COUNT_BITS-1:0] : window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   atr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .out_free  (out_free),
      .emit      (emit),
      .cmd       (cmd)
   );

   atr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .window_length (window_length_ff),
      .high_price    (req_tdata[31:0]),
      .low_price     (req_tdata[63:32]),
      .close_price   (req_tdata[95:64]),
      .cmd           (cmd),
      .status        (status),
      .range_mean    (range_mean),
      .mean_valid    (mean_valid)
   );

   // output word register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_mean_ff <= range_mean;
         rsp_flag_ff <= mean_valid;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_mean_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

endmodule
